// ===== rtl/mffd_pkg.sv =====
package mffd_pkg;

	// encoder resolution, one full turn in counts
	localparam int ANGLE_STEPS = 8192;
	localparam int ANGLE_W     = $clog2(ANGLE_STEPS);
	localparam logic [ANGLE_W-1:0] HALF_TURN = ANGLE_W'(ANGLE_STEPS / 2);

	localparam int TURNS_W    = 48;
	localparam int POSITION_W = TURNS_W + ANGLE_W;
	localparam int ID_W       = 11;
	localparam int BYTE_W     = 8;
	localparam int HALF_W     = 16;
	localparam int INDEX_W    = 4;
	localparam int TICKS_W    = 16;

	// apb register file
	localparam int APB_DATA_W = 32;
	localparam int REG_IDX_W  = 3;
	localparam int PADDR_W    = REG_IDX_W + 2;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_MOTOR_INDEX      = 3'd0,
		REG_INVERT           = 3'd1,
		REG_ALT_TYPE         = 3'd2,
		REG_ALT_BASE_ID      = 3'd3,
		REG_STD_BASE_ID      = 3'd4,
		REG_DISCONNECT_TICKS = 3'd5
	} reg_idx_t;

	localparam logic [INDEX_W-1:0] RST_MOTOR_INDEX      = 4'd1;
	localparam logic               RST_INVERT           = 1'b0;
	localparam logic               RST_ALT_TYPE         = 1'b0;
	localparam logic [ID_W-1:0]    RST_ALT_BASE_ID      = 11'd516;
	localparam logic [ID_W-1:0]    RST_STD_BASE_ID      = 11'd512;
	localparam logic [TICKS_W-1:0] RST_DISCONNECT_TICKS = 16'd100;

	// input opcodes
	localparam logic OPC_FRAME = 1'b0;
	localparam logic OPC_TICK  = 1'b1;

	typedef struct packed {
		logic [INDEX_W-1:0] motor_index;
		logic               invert;
		logic               alt_type;
		logic [ID_W-1:0]    alt_base_id;
		logic [ID_W-1:0]    std_base_id;
		logic [TICKS_W-1:0] disconnect_ticks;
	} cfg_t;

	typedef enum logic [1:0] {
		KIND_NOMATCH = 2'd0,
		KIND_FRAME   = 2'd1,
		KIND_TICK    = 2'd2
	} item_kind_t;

	// one classified word as held in the queue
	typedef struct packed {
		item_kind_t         kind;
		logic [ANGLE_W-1:0] angle;
		logic [HALF_W-1:0]  speed;
		logic [HALF_W-1:0]  torque;
		logic [BYTE_W-1:0]  temp;
		logic [TICKS_W-1:0] reload;
	} entry_t;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

endpackage

// ===== rtl/motor_feedback_frame_decoder.sv =====
// motor feedback frame decoder
// path: an accepted input word is written to a queue slot, then its result is registered
// throughput: one word per cycle while no stall is raised; the two-entry queue absorbs output stall
// reset (arst_n low, asynchronous): registers return to their defaults, tracking state
// and countdown clear (motor offline), queue and output register empty
module motor_feedback_frame_decoder (
	input  logic                                   clk,
	input  logic                                   arst_n,

	// apb register port
	input  logic                                   psel,
	input  logic                                   penable,
	input  logic                                   pwrite,
	input  logic [mffd_pkg::PADDR_W-1:0]           paddr,
	input  logic [mffd_pkg::APB_DATA_W-1:0]        pwdata,
	output logic [mffd_pkg::APB_DATA_W-1:0]        prdata,
	output logic                                   pready,

	// input word: a received frame or a time tick
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic                                   opcode,
	input  logic [mffd_pkg::ID_W-1:0]              frame_id,
	input  logic [mffd_pkg::BYTE_W-1:0]            byte0,
	input  logic [mffd_pkg::BYTE_W-1:0]            byte1,
	input  logic [mffd_pkg::BYTE_W-1:0]            byte2,
	input  logic [mffd_pkg::BYTE_W-1:0]            byte3,
	input  logic [mffd_pkg::BYTE_W-1:0]            byte4,
	input  logic [mffd_pkg::BYTE_W-1:0]            byte5,
	input  logic [mffd_pkg::BYTE_W-1:0]            byte6,

	// result word: state after each input word
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic                                   frame_used,
	output logic [mffd_pkg::ANGLE_W-1:0]           angle,
	output logic signed [mffd_pkg::TURNS_W-1:0]    turns,
	output logic signed [mffd_pkg::POSITION_W-1:0] position,
	output logic signed [mffd_pkg::HALF_W-1:0]     shaft_speed,
	output logic signed [mffd_pkg::HALF_W-1:0]     torque_current,
	output logic signed [mffd_pkg::BYTE_W-1:0]     temperature,
	output logic                                   online
);

	mffd_pkg::cfg_t   cfg_q;
	mffd_pkg::entry_t push_entry;
	mffd_pkg::entry_t head_entry;
	logic             push;
	logic             pop;
	logic             q_full;
	logic             q_not_empty;
	logic [mffd_pkg::REG_IDX_W-1:0] reg_idx;
	logic             wr_en;

	// ---------------------------------------------------------------
	// register file: word-aligned, index in paddr above the byte lanes
	// ---------------------------------------------------------------
	assign pready  = 1'b1;
	assign reg_idx = paddr[mffd_pkg::PADDR_W-1:2];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.motor_index      <= mffd_pkg::RST_MOTOR_INDEX;
			cfg_q.invert           <= mffd_pkg::RST_INVERT;
			cfg_q.alt_type         <= mffd_pkg::RST_ALT_TYPE;
			cfg_q.alt_base_id      <= mffd_pkg::RST_ALT_BASE_ID;
			cfg_q.std_base_id      <= mffd_pkg::RST_STD_BASE_ID;
			cfg_q.disconnect_ticks <= mffd_pkg::RST_DISCONNECT_TICKS;
		end else if (wr_en) begin
			// unused register slots swallow the write
			unique case (reg_idx)
				mffd_pkg::REG_MOTOR_INDEX:
					cfg_q.motor_index <= pwdata[mffd_pkg::INDEX_W-1:0];
				mffd_pkg::REG_INVERT:
					cfg_q.invert <= pwdata[0];
				mffd_pkg::REG_ALT_TYPE:
					cfg_q.alt_type <= pwdata[0];
				mffd_pkg::REG_ALT_BASE_ID:
					cfg_q.alt_base_id <= pwdata[mffd_pkg::ID_W-1:0];
				mffd_pkg::REG_STD_BASE_ID:
					cfg_q.std_base_id <= pwdata[mffd_pkg::ID_W-1:0];
				mffd_pkg::REG_DISCONNECT_TICKS:
					cfg_q.disconnect_ticks <= pwdata[mffd_pkg::TICKS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			mffd_pkg::REG_MOTOR_INDEX:
				prdata[mffd_pkg::INDEX_W-1:0] = cfg_q.motor_index;
			mffd_pkg::REG_INVERT:
				prdata[0] = cfg_q.invert;
			mffd_pkg::REG_ALT_TYPE:
				prdata[0] = cfg_q.alt_type;
			mffd_pkg::REG_ALT_BASE_ID:
				prdata[mffd_pkg::ID_W-1:0] = cfg_q.alt_base_id;
			mffd_pkg::REG_STD_BASE_ID:
				prdata[mffd_pkg::ID_W-1:0] = cfg_q.std_base_id;
			mffd_pkg::REG_DISCONNECT_TICKS:
				prdata[mffd_pkg::TICKS_W-1:0] = cfg_q.disconnect_ticks;
			default: begin
			end
		endcase
	end

	// ---------------------------------------------------------------
	// front: id match and payload decode, straight into the queue
	// ---------------------------------------------------------------
	mffd_front u_front (
		.in_valid (in_valid),
		.in_stall (in_stall),
		.opcode   (opcode),
		.frame_id (frame_id),
		.byte0    (byte0),
		.byte1    (byte1),
		.byte2    (byte2),
		.byte3    (byte3),
		.byte4    (byte4),
		.byte5    (byte5),
		.byte6    (byte6),
		.cfg      (cfg_q),
		.q_full   (q_full),
		.q_push   (push),
		.q_entry  (push_entry)
	);

	// two-entry queue decouples input stall from output stall
	mffd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (pop),
		.not_empty  (q_not_empty),
		.head       (head_entry)
	);

	// ---------------------------------------------------------------
	// back: turn tracking, countdown and the result register
	// ---------------------------------------------------------------
	mffd_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_not_empty    (q_not_empty),
		.q_head         (head_entry),
		.q_pop          (pop),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.frame_used     (frame_used),
		.angle          (angle),
		.turns          (turns),
		.position       (position),
		.shaft_speed    (shaft_speed),
		.torque_current (torque_current),
		.temperature    (temperature),
		.online         (online)
	);

endmodule

// ===== rtl/mffd_front.sv =====
module mffd_front (
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          opcode,
	input  logic [mffd_pkg::ID_W-1:0]     frame_id,
	input  logic [mffd_pkg::BYTE_W-1:0]   byte0,
	input  logic [mffd_pkg::BYTE_W-1:0]   byte1,
	input  logic [mffd_pkg::BYTE_W-1:0]   byte2,
	input  logic [mffd_pkg::BYTE_W-1:0]   byte3,
	input  logic [mffd_pkg::BYTE_W-1:0]   byte4,
	input  logic [mffd_pkg::BYTE_W-1:0]   byte5,
	input  logic [mffd_pkg::BYTE_W-1:0]   byte6,
	input  mffd_pkg::cfg_t                cfg,
	input  logic                          q_full,
	output logic                          q_push,
	output mffd_pkg::entry_t              q_entry
);

	logic [mffd_pkg::ID_W-1:0]    base_id;
	logic [mffd_pkg::ID_W:0]      want_id;
	logic                         id_hit;
	logic [mffd_pkg::HALF_W-1:0]  raw_angle;
	logic [mffd_pkg::HALF_W-1:0]  raw_speed;
	logic [mffd_pkg::HALF_W-1:0]  raw_torque;
	logic [mffd_pkg::ANGLE_W-1:0] ang;

	// sum compared at full width, so an overflowing id never matches
	assign base_id = cfg.alt_type ? cfg.alt_base_id : cfg.std_base_id;
	assign want_id = {1'b0, base_id} + {{(mffd_pkg::ID_W + 1 - mffd_pkg::INDEX_W){1'b0}},
		cfg.motor_index};
	assign id_hit  = ({1'b0, frame_id} == want_id);

	assign raw_angle  = {byte0, byte1};
	assign raw_speed  = {byte2, byte3};
	assign raw_torque = {byte4, byte5};
	assign ang        = raw_angle[mffd_pkg::ANGLE_W-1:0];

	always_comb begin
		q_entry.kind   = mffd_pkg::KIND_NOMATCH;
		if (opcode == mffd_pkg::OPC_TICK) begin
			q_entry.kind = mffd_pkg::KIND_TICK;
		end else if (id_hit) begin
			q_entry.kind = mffd_pkg::KIND_FRAME;
		end
		// mirror is steps-1-angle, i.e. bitwise complement
		q_entry.angle  = cfg.invert ? ~ang : ang;
		q_entry.speed  = cfg.invert ? (~raw_speed + 16'd1) : raw_speed;
		q_entry.torque = cfg.invert ? (~raw_torque + 16'd1) : raw_torque;
		q_entry.temp   = cfg.alt_type ? byte6 : '0;
		q_entry.reload = cfg.disconnect_ticks;
	end

	assign in_stall = q_full;
	assign q_push   = in_valid && !q_full;

endmodule

// ===== rtl/mffd_queue.sv =====
module mffd_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  mffd_pkg::entry_t  push_entry,
	output logic              full,
	input  logic              pop,
	output logic              not_empty,
	output mffd_pkg::entry_t  head
);

	mffd_pkg::entry_t               slot_q [mffd_pkg::QUEUE_DEPTH];
	logic [mffd_pkg::QPTR_W-1:0]    wr_ptr_q;
	logic [mffd_pkg::QPTR_W-1:0]    rd_ptr_q;
	logic [mffd_pkg::QCNT_W-1:0]    count_q;

	localparam logic [mffd_pkg::QPTR_W-1:0] LAST_PTR =
		mffd_pkg::QPTR_W'(mffd_pkg::QUEUE_DEPTH - 1);
	localparam logic [mffd_pkg::QCNT_W-1:0] FULL_CNT =
		mffd_pkg::QCNT_W'(mffd_pkg::QUEUE_DEPTH);

	assign full      = (count_q == FULL_CNT);
	assign not_empty = (count_q != '0);
	assign head      = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/mffd_back.sv =====
module mffd_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            q_not_empty,
	input  mffd_pkg::entry_t                q_head,
	output logic                            q_pop,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            frame_used,
	output logic [mffd_pkg::ANGLE_W-1:0]    angle,
	output logic signed [mffd_pkg::TURNS_W-1:0]    turns,
	output logic signed [mffd_pkg::POSITION_W-1:0] position,
	output logic signed [mffd_pkg::HALF_W-1:0]     shaft_speed,
	output logic signed [mffd_pkg::HALF_W-1:0]     torque_current,
	output logic signed [mffd_pkg::BYTE_W-1:0]     temperature,
	output logic                            online
);

	// tracking state doubles as the output register: it only moves when a word is taken
	logic                             out_valid_q;
	logic                             used_q;
	logic [mffd_pkg::ANGLE_W-1:0]     last_angle_q;
	logic [mffd_pkg::TURNS_W-1:0]     rev_q;
	logic [mffd_pkg::HALF_W-1:0]      speed_q;
	logic [mffd_pkg::HALF_W-1:0]      torque_q;
	logic [mffd_pkg::BYTE_W-1:0]      temp_q;
	logic [mffd_pkg::TICKS_W-1:0]     ticks_q;
	logic                             running_q;

	logic wrap_fwd;
	logic wrap_back;
	logic ticking;

	assign q_pop = q_not_empty && (!out_valid_q || !out_stall);

	assign wrap_fwd  = (last_angle_q > q_head.angle) &&
		((last_angle_q - q_head.angle) > mffd_pkg::HALF_TURN);
	assign wrap_back = (q_head.angle > last_angle_q) &&
		((q_head.angle - last_angle_q) > mffd_pkg::HALF_TURN);
	assign ticking   = running_q && (ticks_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			used_q       <= 1'b0;
			last_angle_q <= '0;
			rev_q        <= '0;
			speed_q      <= '0;
			torque_q     <= '0;
			temp_q       <= '0;
			ticks_q      <= '0;
			running_q    <= 1'b0;
		end else begin
			if (q_pop) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (q_pop) begin
				used_q <= (q_head.kind == mffd_pkg::KIND_FRAME);
				unique case (q_head.kind)
					mffd_pkg::KIND_FRAME: begin
						last_angle_q <= q_head.angle;
						speed_q      <= q_head.speed;
						torque_q     <= q_head.torque;
						temp_q       <= q_head.temp;
						ticks_q      <= q_head.reload;
						running_q    <= 1'b1;
						if (wrap_fwd) begin
							rev_q <= rev_q + 1'b1;
						end else if (wrap_back) begin
							rev_q <= rev_q - 1'b1;
						end
					end
					mffd_pkg::KIND_TICK: begin
						if (ticking) begin
							ticks_q <= ticks_q - 1'b1;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign frame_used     = used_q;
	assign angle          = last_angle_q;
	assign turns          = rev_q;
	// steps per turn is a power of two, so the product is a plain concatenation
	assign position       = {rev_q, last_angle_q};
	assign shaft_speed    = speed_q;
	assign torque_current = torque_q;
	assign temperature    = temp_q;
	assign online         = ticking;

endmodule

// ===== rtl/mffd_checker.sv =====
module mffd_checker (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	input  logic                                   in_stall,
	input  logic                                   out_valid,
	input  logic                                   out_stall,
	input  logic                                   frame_used,
	input  logic [mffd_pkg::ANGLE_W-1:0]           angle,
	input  logic signed [mffd_pkg::TURNS_W-1:0]    turns,
	input  logic signed [mffd_pkg::POSITION_W-1:0] position
);

	// no word is offered once reset has been seen at an edge
	a_reset_quiet: assert property (@(posedge clk) !arst_n |=> !out_valid)
		else $error("result word presented during reset");

	// whenever a result word is offered, position is turns scaled by one turn plus the angle
	a_position: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> position == {turns, angle})
		else $error("position disagrees with turns and angle");

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(position) && $stable(frame_used))
		else $error("stalled result word changed");

	// a stalled input word stays offered
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid)
		else $error("stalled input word withdrawn");

endmodule

bind motor_feedback_frame_decoder mffd_checker u_mffd_checker (.*);
